// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the timed key event queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The antecedent implies the consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/tkq_pkg.sv =====
// Types, codes and the route decode function of the timed key event queue.
package tkq_pkg;

   localparam int QUEUE_DEPTH_DEF = 64;

   localparam logic OP_SCHEDULE = 1'b0;
   localparam logic OP_TICK     = 1'b1;

   localparam logic [2:0] KIND_QUEUED     = 3'd0;
   localparam logic [2:0] KIND_SPECIAL    = 3'd1;
   localparam logic [2:0] KIND_DROPPED    = 3'd2;
   localparam logic [2:0] KIND_IDLE       = 3'd3;
   localparam logic [2:0] KIND_DISPATCHED = 3'd4;

   localparam logic [1:0] ACT_NONE   = 2'd0;
   localparam logic [1:0] ACT_BOOT   = 2'd1;
   localparam logic [1:0] ACT_HEADER = 2'd2;

   localparam logic [2:0] TGT_HEADER   = 3'd0;
   localparam logic [2:0] TGT_CONSUMER = 3'd1;
   localparam logic [2:0] TGT_SYSTEM   = 3'd2;
   localparam logic [2:0] TGT_USB      = 3'd3;
   localparam logic [2:0] TGT_SERIAL   = 3'd4;
   localparam logic [2:0] TGT_NONE     = 3'd5;

   localparam logic [1:0] PATH_USB    = 2'd0;
   localparam logic [1:0] PATH_SERIAL = 2'd1;

   localparam logic CSR_EVENT_DELAY = 1'b0;
   localparam logic CSR_OUTPUT_PATH = 1'b1;

   localparam logic [7:0] CODE_SPECIAL_END = 8'd4;
   localparam logic [7:0] CODE_BOOT        = 8'd2;
   localparam logic [7:0] CODE_HEADER      = 8'd3;
   localparam logic [7:0] CODE_CONSUMER_LO = 8'he8;
   localparam logic [7:0] CODE_SYSTEM_LO   = 8'ha5;
   localparam logic [7:0] CODE_SYSTEM_HI   = 8'ha7;
   localparam logic [7:0] CODE_LAYER_MASK  = 8'hf8;
   localparam logic [7:0] CODE_LAYER_VAL   = 8'ha8;

   typedef struct packed {
      logic        op;
      logic [31:0] due_time;
      logic        released;
      logic [6:0]  other_flags;
      logic [7:0]  key_code;
      logic [31:0] now;
   } req_type;

   typedef struct packed {
      logic [2:0]  result_kind;
      logic [1:0]  special_action;
      logic [2:0]  target;
      logic [7:0]  out_code;
      logic [31:0] out_time;
      logic        out_released;
      logic [6:0]  out_other_flags;
      logic        keypress_notify;
   } rsp_type;

   typedef struct packed {
      logic [31:0] due_time;
      logic        released;
      logic [6:0]  other_flags;
      logic [7:0]  key_code;
   } slot_type;

   // Route of a dispatched event by its code and the configured report path.
   function automatic logic [2:0] target_of(input logic [7:0] code, input logic [1:0] path);
      logic [2:0] t;
      if (code < CODE_SPECIAL_END) begin
         t = TGT_HEADER;
      end else if (code >= CODE_CONSUMER_LO) begin
         t = TGT_CONSUMER;
      end else if (code >= CODE_SYSTEM_LO && code <= CODE_SYSTEM_HI) begin
         t = TGT_SYSTEM;
      end else if (path == PATH_USB) begin
         t = TGT_USB;
      end else if (path == PATH_SERIAL) begin
         t = TGT_SERIAL;
      end else begin
         t = TGT_NONE;
      end
      return t;
   endfunction

endpackage

// ===== rtl/tkq_slot_ram.sv =====
// Event slot memory: one write port, one read port with registered data.
module tkq_slot_ram #(
   parameter int QUEUE_DEPTH = tkq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [$clog2(QUEUE_DEPTH)-1:0] wr_addr,
   input  tkq_pkg::slot_type              wr_data,
   input  logic [$clog2(QUEUE_DEPTH)-1:0] rd_addr,
   output tkq_pkg::slot_type              rd_data
);
   tkq_pkg::slot_type mem [QUEUE_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== rtl/timed_key_event_queue.sv =====
// Timed key event queue: a ring of timestamped key events with a dispatching tick.
//
// A request is taken when start is high and busy is low; each request gives exactly one
// result, shown for one cycle with rsp_strobe, which the receiver must take then as it cannot
// stall the block. Special, layer-modifier and cooldown requests answer in the cycle after
// acceptance and leave busy low. Storing an event probes the valid bits in turn from the slot
// after the tail, at most QUEUE_DEPTH of them. A tick that finds no cooldown first skips the
// freed slots at the head, then starts the scan and examines each slot in ST_RD and then
// ST_CHK, as each slot time comes from the memory in the cycle after its address. The slots
// skipped and examined together never exceed QUEUE_DEPTH. Valid bits reset at once.
`include "assert_macros.svh"

module timed_key_event_queue #(
   parameter int QUEUE_DEPTH = tkq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  tkq_pkg::req_type req,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [15:0]      csr_data,
   output logic             rsp_strobe,
   output tkq_pkg::rsp_type rsp
);
   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SCHED = 5'b00010,
      ST_HEAD  = 5'b00100,
      ST_RD    = 5'b01000,
      ST_CHK   = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   tkq_pkg::req_type     cur_ff, cur_in;
   logic [IDX_W-1:0]     pos_ff, pos_in;
   logic [IDX_W-1:0]     cnt_ff, cnt_in;
   logic [IDX_W-1:0]     head_ff, head_in;
   logic [IDX_W-1:0]     tail_ff, tail_in;
   logic [15:0]          cool_ff, cool_in;
   logic [15:0]          delay_ff, delay_in;
   logic [1:0]           path_ff, path_in;
   logic [QUEUE_DEPTH-1:0] valid_ff, valid_in;
   tkq_pkg::rsp_type     rsp_ff, rsp_in;
   logic                 strobe_ff, strobe_in;

   logic                 ram_we;
   tkq_pkg::slot_type    ram_wdata, ram_rdata;

   function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
      return (i == LAST_IDX) ? '0 : i + 1'b1;
   endfunction

   function automatic tkq_pkg::rsp_type echo(input tkq_pkg::req_type r, input logic [2:0] kind,
                                             input logic [1:0] act);
      tkq_pkg::rsp_type o;
      o.result_kind     = kind;
      o.special_action  = act;
      o.target          = tkq_pkg::TGT_NONE;
      o.out_code        = r.key_code;
      o.out_time        = r.due_time;
      o.out_released    = r.released;
      o.out_other_flags = r.other_flags;
      o.keypress_notify = 1'b0;
      return o;
   endfunction

   function automatic tkq_pkg::rsp_type idle_rsp();
      tkq_pkg::rsp_type o;
      o             = '0;
      o.result_kind = tkq_pkg::KIND_IDLE;
      o.target      = tkq_pkg::TGT_NONE;
      return o;
   endfunction

   tkq_slot_ram #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (pos_ff),
      .wr_data (ram_wdata),
      .rd_addr (pos_ff),
      .rd_data (ram_rdata)
   );

   assign ram_wdata.due_time    = cur_ff.due_time;
   assign ram_wdata.released    = cur_ff.released;
   assign ram_wdata.other_flags = cur_ff.other_flags;
   assign ram_wdata.key_code    = cur_ff.key_code;

   always_comb begin
      logic [1:0] act;
      logic       drel;
      state_in  = state_ff;
      cur_in    = cur_ff;
      pos_in    = pos_ff;
      cnt_in    = cnt_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      cool_in   = cool_ff;
      valid_in  = valid_ff;
      rsp_in    = rsp_ff;
      strobe_in = 1'b0;
      ram_we    = 1'b0;
      act       = tkq_pkg::ACT_NONE;
      drel      = 1'b0;
      delay_in  = (csr_we && csr_index == tkq_pkg::CSR_EVENT_DELAY) ? csr_data : delay_ff;
      path_in   = (csr_we && csr_index == tkq_pkg::CSR_OUTPUT_PATH) ? csr_data[1:0] : path_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cur_in = req;
               if (req.op == tkq_pkg::OP_SCHEDULE) begin
                  if (req.key_code < tkq_pkg::CODE_SPECIAL_END) begin
                     if (req.key_code == tkq_pkg::CODE_BOOT) begin
                        act = tkq_pkg::ACT_BOOT;
                     end else if (req.key_code == tkq_pkg::CODE_HEADER) begin
                        act = tkq_pkg::ACT_HEADER;
                     end
                     strobe_in = 1'b1;
                     rsp_in = req.released ? echo(req, tkq_pkg::KIND_DROPPED, tkq_pkg::ACT_NONE)
                                           : echo(req, tkq_pkg::KIND_SPECIAL, act);
                  end else if ((req.key_code & tkq_pkg::CODE_LAYER_MASK)
                               == tkq_pkg::CODE_LAYER_VAL) begin
                     strobe_in = 1'b1;
                     rsp_in    = echo(req, tkq_pkg::KIND_DROPPED, tkq_pkg::ACT_NONE);
                  end else begin
                     pos_in   = ring_next(tail_ff);
                     cnt_in   = '0;
                     state_in = ST_SCHED;
                  end
               end else if (cool_ff != 16'd0) begin
                  cool_in   = cool_ff - 16'd1;
                  strobe_in = 1'b1;
                  rsp_in    = idle_rsp();
               end else begin
                  state_in = ST_HEAD;
               end
            end
         end
         ST_SCHED: begin
            if (!valid_ff[pos_ff]) begin
               valid_in[pos_ff] = 1'b1;
               ram_we    = 1'b1;
               tail_in   = pos_ff;
               strobe_in = 1'b1;
               rsp_in    = echo(cur_ff, tkq_pkg::KIND_QUEUED, tkq_pkg::ACT_NONE);
               state_in  = ST_IDLE;
            end else if (cnt_ff == LAST_IDX) begin
               strobe_in = 1'b1;
               rsp_in    = echo(cur_ff, tkq_pkg::KIND_DROPPED, tkq_pkg::ACT_NONE);
               state_in  = ST_IDLE;
            end else begin
               pos_in = ring_next(pos_ff);
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_HEAD: begin
            if (head_ff == tail_ff || valid_ff[head_ff]) begin
               pos_in   = head_ff;
               state_in = ST_RD;
            end else begin
               head_in = ring_next(head_ff);
            end
         end
         ST_RD: begin
            state_in = ST_CHK;
         end
         ST_CHK: begin
            if (valid_ff[pos_ff] && ram_rdata.due_time <= cur_ff.now) begin
               drel = ram_rdata.released || (ram_rdata.key_code < tkq_pkg::CODE_SPECIAL_END);
               rsp_in.result_kind     = tkq_pkg::KIND_DISPATCHED;
               rsp_in.special_action  = tkq_pkg::ACT_NONE;
               rsp_in.target          = tkq_pkg::target_of(ram_rdata.key_code, path_ff);
               rsp_in.out_code        = ram_rdata.key_code;
               rsp_in.out_time        = ram_rdata.due_time;
               rsp_in.out_released    = drel;
               rsp_in.out_other_flags = ram_rdata.other_flags;
               rsp_in.keypress_notify = !drel;
               if (!drel) begin
                  cool_in = delay_ff;
               end
               valid_in[pos_ff] = 1'b0;
               strobe_in = 1'b1;
               state_in  = ST_IDLE;
            end else if (pos_ff == tail_ff) begin
               strobe_in = 1'b1;
               rsp_in    = idle_rsp();
               state_in  = ST_IDLE;
            end else begin
               pos_in   = ring_next(pos_ff);
               state_in = ST_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         head_ff   <= '0;
         tail_ff   <= '0;
         cool_ff   <= '0;
         delay_ff  <= '0;
         path_ff   <= '0;
         valid_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         cool_ff   <= cool_in;
         delay_ff  <= delay_in;
         path_ff   <= path_in;
         valid_ff  <= valid_in;
         strobe_ff <= strobe_in;
      end
      cur_ff <= cur_in;
      pos_ff <= pos_in;
      cnt_ff <= cnt_in;
      rsp_ff <= rsp_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp        = rsp_ff;

   // An accepted request either answers next cycle or keeps the block busy.
   `ASSERT_NEXT(a_accept_progress, clock, reset, start && !busy, busy || rsp_strobe)
   // A queued event leaves the tail on a valid slot.
   `ASSERT_IMPLIES(a_queued_tail_valid, clock, reset,
      rsp_strobe && rsp.result_kind == tkq_pkg::KIND_QUEUED, valid_ff[tail_ff])
   // A dispatched press has just reloaded the cooldown.
   `ASSERT_IMPLIES(a_notify_cooldown, clock, reset,
      rsp_strobe && rsp.keypress_notify, cool_ff == delay_ff)
endmodule

// ===== dv/tkq_checker.sv =====
// Checker of the timed key event queue: predicts each result and compares it field by field.
module tkq_checker
   import tkq_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req,
   input  logic    csr_we,
   input  logic    csr_index,
   input  logic [15:0] csr_data,
   input  logic    rsp_strobe,
   input  rsp_type rsp,
   output int      fail_count,
   output int      pending,
   output int      result_count
);

   logic              ring_used [DEPTH];
   slot_type          ring_slot [DEPTH];
   int unsigned       head_pos;
   int unsigned       tail_pos;
   logic [15:0]       cooldown;
   logic [15:0]       press_delay;
   logic [1:0]        report_path;
   rsp_type           due_results [$];

   function automatic int unsigned wrap_next(int unsigned i);
      return (i + 1 >= DEPTH) ? 0 : i + 1;
   endfunction

   function automatic logic is_due(int unsigned i, logic [31:0] now);
      return ring_used[i] && (ring_slot[i].due_time <= now);
   endfunction

   // Applies one request to the shadow ring and returns the result it should give.
   function automatic rsp_type apply_request(req_type r);
      rsp_type     o;
      int unsigned p;
      logic        found;
      logic [7:0]  c;
      o = '0;
      o.target = TGT_NONE;
      if (r.op == OP_SCHEDULE) begin
         o.out_code = r.key_code;
         o.out_time = r.due_time;
         o.out_released = r.released;
         o.out_other_flags = r.other_flags;
         if (r.key_code < CODE_SPECIAL_END) begin
            if (r.released) begin
               o.result_kind = KIND_DROPPED;
            end else begin
               o.result_kind = KIND_SPECIAL;
               if (r.key_code == CODE_BOOT) o.special_action = ACT_BOOT;
               else if (r.key_code == CODE_HEADER) o.special_action = ACT_HEADER;
            end
            return o;
         end
         if ((r.key_code & CODE_LAYER_MASK) == CODE_LAYER_VAL) begin
            o.result_kind = KIND_DROPPED;
            return o;
         end
         p = tail_pos;
         found = 1'b0;
         for (int n = 0; n < DEPTH; n++) begin
            p = wrap_next(p);
            if (!ring_used[p]) begin
               found = 1'b1;
               break;
            end
         end
         if (!found) begin
            o.result_kind = KIND_DROPPED;
            return o;
         end
         ring_used[p] = 1'b1;
         ring_slot[p] = {r.due_time, r.released, r.other_flags, r.key_code};
         tail_pos = p;
         o.result_kind = KIND_QUEUED;
         return o;
      end
      o.result_kind = KIND_IDLE;
      if (cooldown != 0) begin
         cooldown--;
         return o;
      end
      for (int n = 0; n < DEPTH; n++) begin
         if (head_pos == tail_pos || ring_used[head_pos]) break;
         head_pos = wrap_next(head_pos);
      end
      p = head_pos;
      for (int n = 0; n < DEPTH; n++) begin
         if (p == tail_pos || is_due(p, r.now)) break;
         p = wrap_next(p);
      end
      if (!is_due(p, r.now)) return o;
      c = ring_slot[p].key_code;
      o.result_kind = KIND_DISPATCHED;
      o.out_code = c;
      o.out_time = ring_slot[p].due_time;
      o.out_other_flags = ring_slot[p].other_flags;
      o.out_released = ring_slot[p].released;
      if (c < CODE_SPECIAL_END) begin
         o.target = TGT_HEADER;
         o.out_released = 1'b1;
      end else if (c >= CODE_CONSUMER_LO) o.target = TGT_CONSUMER;
      else if (c >= CODE_SYSTEM_LO && c <= CODE_SYSTEM_HI) o.target = TGT_SYSTEM;
      else if (report_path == PATH_USB) o.target = TGT_USB;
      else if (report_path == PATH_SERIAL) o.target = TGT_SERIAL;
      else o.target = TGT_NONE;
      if (!o.out_released) begin
         cooldown = press_delay;
         o.keypress_notify = 1'b1;
      end
      ring_used[p] = 1'b0;
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH at result %0d: %s got %0h expected %0h", result_count, what, got,
               want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      rsp_type w;
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) ring_used[i] = 1'b0;
         head_pos = 0;
         tail_pos = 0;
         cooldown = '0;
         press_delay = '0;
         report_path = '0;
         due_results.delete();
         fail_count = 0;
         result_count = 0;
      end else begin
         // A result from an earlier request is compared before this edge's request is predicted.
         if (rsp_strobe) begin
            if (due_results.size() == 0) begin
               report_mismatch("unexpected result, kind", rsp.result_kind, '1);
            end else begin
               w = due_results.pop_front();
               if (rsp.result_kind != w.result_kind)
                  report_mismatch("result_kind", rsp.result_kind, w.result_kind);
               if (rsp.special_action != w.special_action)
                  report_mismatch("special_action", rsp.special_action, w.special_action);
               if (rsp.target != w.target) report_mismatch("target", rsp.target, w.target);
               if (rsp.out_code != w.out_code)
                  report_mismatch("out_code", rsp.out_code, w.out_code);
               if (rsp.out_time != w.out_time)
                  report_mismatch("out_time", rsp.out_time, w.out_time);
               if (rsp.out_released != w.out_released)
                  report_mismatch("out_released", rsp.out_released, w.out_released);
               if (rsp.out_other_flags != w.out_other_flags)
                  report_mismatch("out_other_flags", rsp.out_other_flags, w.out_other_flags);
               if (rsp.keypress_notify != w.keypress_notify)
                  report_mismatch("keypress_notify", rsp.keypress_notify, w.keypress_notify);
            end
            result_count++;
         end
         if (csr_we) begin
            if (csr_index == CSR_EVENT_DELAY) press_delay = csr_data;
            else report_path = csr_data[1:0];
         end
         if (start && !busy) due_results.push_back(apply_request(req));
      end
      pending = due_results.size();
   end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top of the timed key event queue: stimulus, configuration phases and verdict.
module tb_top;
   import tkq_pkg::*;

   localparam int LIMIT_CYCLES = 1500000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req = '0;
   logic        csr_we = 1'b0;
   logic        csr_index = CSR_EVENT_DELAY;
   logic [15:0] csr_data = '0;
   logic        rsp_strobe;
   rsp_type     rsp;
   int          fail_count;
   int          pending;
   int          result_count;
   int          cycle_count = 0;
   int          sent_count = 0;
   logic [31:0] clock_now = 32'd1000;
   logic        quiet = 1'b0;

   timed_key_event_queue u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req(req),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data),
      .rsp_strobe(rsp_strobe), .rsp(rsp)
   );

   tkq_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req(req),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data),
      .rsp_strobe(rsp_strobe), .rsp(rsp), .fail_count(fail_count),
      .pending(pending), .result_count(result_count)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Holds the request until it is taken; a random gap may come first. Start stays high
   // afterwards so that the next request can follow at once; drain_results drops it.
   task automatic send_request(req_type r);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req <= r;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
      sent_count++;
   endtask

   task automatic write_register(logic idx, logic [15:0] value);
      csr_index <= idx;
      csr_data <= value;
      csr_we <= 1'b1;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   function automatic req_type make_event(logic [7:0] code, logic [31:0] t, logic rel);
      req_type r;
      r = '0;
      r.op = OP_SCHEDULE;
      r.key_code = code;
      r.due_time = t;
      r.released = rel;
      r.other_flags = 7'($urandom);
      r.now = $urandom;
      return r;
   endfunction

   function automatic req_type make_tick(logic [31:0] t);
      req_type r;
      r = '0;
      r.op = OP_TICK;
      r.now = t;
      r.due_time = $urandom;
      r.key_code = 8'($urandom);
      r.released = 1'($urandom);
      r.other_flags = 7'($urandom);
      return r;
   endfunction

   // Mostly plain keys, with some of every code class.
   function automatic logic [7:0] pick_code();
      case ($urandom_range(0, 9))
         0: return 8'($urandom_range(0, 3));
         1: return 8'($urandom_range(8'ha8, 8'haf));
         2: return 8'($urandom_range(8'he8, 8'hff));
         3: return 8'($urandom_range(8'ha5, 8'ha7));
         default: return 8'($urandom_range(4, 8'hff));
      endcase
   endfunction

   task automatic run_phase(int count, int tick_percent);
      logic [31:0] t;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < tick_percent) begin
            clock_now = clock_now + $urandom_range(0, 40);
            send_request(make_tick($urandom_range(0, 7) == 0 ? 32'($urandom) : clock_now));
         end else begin
            case ($urandom_range(0, 5))
               0: t = $urandom;
               1: t = 32'hffff_ffff;
               default: t = clock_now + $urandom_range(0, 60) - 20;
            endcase
            send_request(make_event(pick_code(), t, 1'($urandom)));
         end
      end
   endtask

   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: every special code both ways, layer modifiers, code classes and extremes.
      for (int c = 0; c < 4; c++) begin
         send_request(make_event(8'(c), 32'd5, 1'b0));
         send_request(make_event(8'(c), 32'd5, 1'b1));
      end
      send_request(make_event(8'ha8, 32'd0, 1'b0));
      send_request(make_event(8'haf, 32'hffff_ffff, 1'b1));
      send_request(make_event(8'hff, 32'd0, 1'b0));
      send_request(make_event(8'he8, 32'd1, 1'b1));
      send_request(make_event(8'ha5, 32'd2, 1'b0));
      send_request(make_event(8'ha7, 32'hffff_ffff, 1'b0));
      send_request(make_event(8'd4, 32'd3, 1'b0));
      send_request(make_event(8'ha4, 32'd3, 1'b1));
      send_request(make_tick(32'd0));
      send_request(make_tick(32'd10));
      send_request(make_tick(32'hffff_ffff));
      for (int i = 0; i < 5; i++) send_request(make_tick(32'hffff_ffff));
      drain_results();

      // Fill the ring past full so that drops appear, then empty it.
      for (int i = 0; i < 70; i++) send_request(make_event(8'($urandom_range(4, 8'ha4)),
                                                           32'($urandom_range(0, 500)), 1'b0));
      for (int i = 0; i < 70; i++) send_request(make_tick(32'hffff_ffff));
      drain_results();

      write_register(CSR_EVENT_DELAY, 16'd3);
      write_register(CSR_OUTPUT_PATH, 16'(PATH_SERIAL));
      run_phase(120, 40);
      drain_results();
      write_register(CSR_OUTPUT_PATH, 16'd2);
      write_register(CSR_EVENT_DELAY, 16'd0);
      run_phase(100, 50);
      drain_results();
      write_register(CSR_OUTPUT_PATH, 16'd3);
      write_register(CSR_EVENT_DELAY, 16'hffff);
      run_phase(40, 50);
      drain_results();
      write_register(CSR_OUTPUT_PATH, 16'(PATH_USB));
      write_register(CSR_EVENT_DELAY, 16'($urandom_range(0, 2)));
      run_phase(100, 45);
      quiet = 1'b1;
      run_phase(40, 45);

      drain_results();
      repeat (200) @(negedge clock);
      $display("Sent %0d requests and checked %0d results over four register settings,",
               sent_count, result_count);
      $display("including special codes, layer drops, a full ring and cooldown ticks.");
      if (fail_count == 0 && pending == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches, %0d results missing", fail_count, pending);
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/tkq_pkg.sv
rtl/tkq_slot_ram.sv
rtl/timed_key_event_queue.sv
dv/tkq_checker.sv
dv/tb_top.sv
